[design/motor_speed_regulator_core_macros.svh]
// Assertion macros used by the checker file of the speed regulator.
`ifndef MOTOR_SPEED_REGULATOR_CORE_MACROS_SVH
`define MOTOR_SPEED_REGULATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("speed regulator check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("speed regulator check failed");

`endif

[design/msr_pkg.sv]
`timescale 1ns / 1ps
package msr_pkg;

    // Internal widths of the count and time differences.
    localparam int COUNT_WIDTH = 32;
    localparam int TIME_WIDTH  = 32;

    // Fixed widths of the request and result fields.
    localparam int IN_CNT_W = 32;
    localparam int IN_TIM_W = 32;
    localparam int RPM_W    = 16;
    localparam int DRIVE_W  = 16;

    // Configuration registers.
    localparam int SCALE_W     = 32;
    localparam int GAIN_W      = 16;
    localparam int SCALE_FRAC  = 16;
    localparam int GAIN_FRAC   = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(41943);

    // Shared multiplier and divider sizes.
    localparam int PROD_W = COUNT_WIDTH + SCALE_W;
    localparam int DVD_W  = PROD_W - SCALE_FRAC;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    // Error magnitude never exceeds 65535, so it fits in one rpm word.
    localparam int EMAG_W = RPM_W;
    localparam int STEP_W = EMAG_W + GAIN_W + 1 - GAIN_FRAC;
    localparam int SUM_W  = STEP_W + 2;

    localparam int DRIVE_MAX = 32767;
    localparam int RPM_MAX   = 32767;
    localparam int RPM_NEG_MAG = 32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE = 1'b0,
        REG_GAIN  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[design/msr_cmd_if.sv]
`timescale 1ns / 1ps
interface msr_cmd_if;
    import msr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [IN_CNT_W-1:0] encoder_count;
    logic [IN_TIM_W-1:0]        time_ms;
    logic signed [RPM_W-1:0]    target_rpm;

    modport source (output valid, output encoder_count, output time_ms,
                    output target_rpm, input ready);
    modport sink (input valid, input encoder_count, input time_ms,
                  input target_rpm, output ready);
endinterface

[design/msr_res_if.sv]
`timescale 1ns / 1ps
interface msr_res_if;
    import msr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [RPM_W-1:0]   measured_rpm;
    logic                      stalled;
    logic                      time_fault;

    modport source (output valid, output drive, output measured_rpm,
                    output stalled, output time_fault, input ready);
    modport sink (input valid, input drive, input measured_rpm,
                  input stalled, input time_fault, output ready);
endinterface

[design/msr_mult.sv]
`timescale 1ns / 1ps
module msr_mult (
    input  logic                          clk,
    input  logic                          load,
    input  logic [msr_pkg::COUNT_WIDTH-1:0] a,
    input  logic [msr_pkg::SCALE_W-1:0]   b,
    output logic [msr_pkg::PROD_W-1:0]    prod
);
    import msr_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // Unsigned product, registered; it holds until the next load.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign prod = prod_reg;
endmodule

[design/msr_div.sv]
`timescale 1ns / 1ps
module msr_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [msr_pkg::DVD_W-1:0]    dividend,
    input  logic [msr_pkg::TIME_WIDTH-1:0] divisor,
    output logic [msr_pkg::DVD_W-1:0]    quotient,
    output msr_pkg::div_status_t         status
);
    import msr_pkg::*;

    logic [TIME_WIDTH:0]    rem_reg;
    logic [DVD_W-1:0]       quo_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [TIME_WIDTH:0]    trial;
    logic                   fits;

    // Restoring division, one quotient bit per cycle, MSB first. The
    // dividend shifts out of quo_reg while quotient bits shift in.
    assign trial = {rem_reg[TIME_WIDTH-1:0], quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, divisor}) : trial;
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;
endmodule

[design/motor_speed_regulator_core.sv]
`timescale 1ns / 1ps
// Integral motor speed regulator fed by an incremental encoder.
// The cmd channel carries one request per control tick: the encoder count,
// a millisecond timestamp and the target speed in rpm. The res channel
// returns one result per request: the new drive level (Q1.15), the average
// speed since the previous request, a stall flag and a time fault flag.
// The cfg port writes scale_factor (index 0) and loop_gain (index 1);
// write it only while no request is in flight.
// A request with a nonzero target passes from acceptance to a loaded result
// through the bit-serial divider (48 quotient bits, then a done flag)
// that turns the scaled count delta into rpm, and through sequencer steps
// around a shared 32x32 multiplier used for the scaling and the loop gain.
// A zero time delta skips the division; a zero target gives a zero result
// and leaves the state alone.
// cmd.ready is high only while the sequencer is idle, so one request is in work
// at a time and the next request waits until the previous one has finished.
// The result sits in an output register; a stalled receiver does not stop
// the next request from being accepted, but the sequencer waits at its end
// until the register is free. Reset clears the held drive level, the last
// count and time, and loads the register reset values.
module motor_speed_regulator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [msr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msr_pkg::CFG_DATA_W-1:0] cfg_data,
    msr_cmd_if.sink                        cmd,
    msr_res_if.source                      res
);
    import msr_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PREP  = 10'b0000000010,
        S_MUL1  = 10'b0000000100,
        S_DIVST = 10'b0000001000,
        S_DIVW  = 10'b0000010000,
        S_SAT   = 10'b0000100000,
        S_ERR   = 10'b0001000000,
        S_MUL2  = 10'b0010000000,
        S_UPD   = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [SCALE_W-1:0] scale_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // Regulator state.
    logic [COUNT_WIDTH-1:0]    last_count_reg;
    logic [TIME_WIDTH-1:0]     last_time_reg;
    logic signed [DRIVE_W-1:0] drive_level_reg;

    // Captured request.
    logic signed [IN_CNT_W-1:0] cnt_in_reg;
    logic [IN_TIM_W-1:0]        tim_in_reg;
    logic signed [RPM_W-1:0]    target_reg;

    // Working values.
    logic [COUNT_WIDTH-1:0]  mag_reg;
    logic                    neg_reg;
    logic [TIME_WIDTH-1:0]   dt_reg;
    logic signed [RPM_W-1:0] speed_reg;
    logic                    fault_reg;
    logic                    zero_reg;
    logic [EMAG_W-1:0]       emag_reg;
    logic                    eneg_reg;

    // Output register.
    logic                      res_valid_reg;
    logic signed [DRIVE_W-1:0] res_drive_reg;
    logic signed [RPM_W-1:0]   res_rpm_reg;
    logic                      res_stalled_reg;
    logic                      res_fault_reg;

    // Datapath signals.
    logic [COUNT_WIDTH-1:0] cnt_ext;
    logic [COUNT_WIDTH-1:0] dc;
    logic [TIME_WIDTH-1:0]  dt;
    logic [COUNT_WIDTH-1:0] mul_a;
    logic [SCALE_W-1:0]     mul_b;
    logic                   mul_load;
    logic [PROD_W-1:0]      prod;
    logic [DVD_W-1:0]       quotient;
    div_status_t            div_st;
    logic signed [RPM_W-1:0] speed_sat;
    logic signed [RPM_W:0]  err;
    logic [RPM_W:0]         err_abs;
    logic [STEP_W-1:0]      step_mag;
    logic signed [SUM_W-1:0] drive_sum;
    logic signed [DRIVE_W-1:0] drive_new;
    logic                   cmd_fire;
    logic                   res_free;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign res_free = !res_valid_reg || res.ready;

    // Count deltas wrap in COUNT_WIDTH bits; the count is sign extended first.
    assign cnt_ext = COUNT_WIDTH'(cnt_in_reg);
    assign dc      = cnt_ext - last_count_reg;
    assign dt      = TIME_WIDTH'(tim_in_reg) - last_time_reg;

    // The shared multiplier scales the count magnitude first and the speed
    // error magnitude later.
    assign mul_a    = (state_reg == S_MUL2) ? COUNT_WIDTH'(emag_reg) : mag_reg;
    assign mul_b    = (state_reg == S_MUL2) ? SCALE_W'(gain_reg) : scale_reg;
    assign mul_load = (state_reg == S_MUL1) || (state_reg == S_MUL2);

    msr_mult u_mult (
        .clk  (clk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    msr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIVST),
        .dividend (prod[PROD_W-1:SCALE_FRAC]),
        .divisor  (dt_reg),
        .quotient (quotient),
        .status   (div_st)
    );

    // Apply the sign and saturate to the rpm range.
    always_comb
    begin
        if (neg_reg)
        begin
            if (quotient > DVD_W'(RPM_NEG_MAG))
            begin
                speed_sat = -RPM_W'(RPM_NEG_MAG);
            end
            else
            begin
                speed_sat = -RPM_W'(quotient);
            end
        end
        else
        begin
            if (quotient > DVD_W'(RPM_MAX))
            begin
                speed_sat = RPM_W'(RPM_MAX);
            end
            else
            begin
                speed_sat = RPM_W'(quotient);
            end
        end
    end

    assign err     = (RPM_W+1)'(target_reg) - (RPM_W+1)'(speed_reg);
    assign err_abs = err[RPM_W] ? (RPM_W+1)'(-err) : (RPM_W+1)'(err);

    // Rounded gain step, ties away from zero, then the clamped integration.
    assign step_mag  = STEP_W'((prod + PROD_W'(1 << (GAIN_FRAC - 1))) >> GAIN_FRAC);
    assign drive_sum = eneg_reg ? (SUM_W'(drive_level_reg) - SUM_W'(step_mag))
                                : (SUM_W'(drive_level_reg) + SUM_W'(step_mag));

    always_comb
    begin
        if (drive_sum > SUM_W'(DRIVE_MAX))
        begin
            drive_new = DRIVE_W'(DRIVE_MAX);
        end
        else if (drive_sum < -SUM_W'(DRIVE_MAX))
        begin
            drive_new = -DRIVE_W'(DRIVE_MAX);
        end
        else
        begin
            drive_new = DRIVE_W'(drive_sum);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (target_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (dt == '0)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:  state_next = S_DIVST;
            S_DIVST: state_next = S_DIVW;
            S_DIVW:
            begin
                if (div_st.done)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:   state_next = S_ERR;
            S_ERR:   state_next = S_MUL2;
            S_MUL2:  state_next = S_UPD;
            S_UPD:   state_next = S_FIN;
            S_FIN:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            scale_reg       <= SCALE_RESET;
            gain_reg        <= GAIN_RESET;
            last_count_reg  <= '0;
            last_time_reg   <= '0;
            drive_level_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCALE: scale_reg <= SCALE_W'(cfg_data);
                    REG_GAIN:  gain_reg  <= GAIN_W'(cfg_data);
                    default:   ;
                endcase
            end

            // A nonzero target always records the new count and time.
            if ((state_reg == S_PREP) && (target_reg != '0))
            begin
                last_count_reg <= cnt_ext;
                last_time_reg  <= dt + last_time_reg;
            end

            if (state_reg == S_UPD)
            begin
                drive_level_reg <= drive_new;
            end

            if ((state_reg == S_FIN) && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cnt_in_reg <= cmd.encoder_count;
            tim_in_reg <= cmd.time_ms;
            target_reg <= cmd.target_rpm;
        end

        if (state_reg == S_PREP)
        begin
            neg_reg   <= dc[COUNT_WIDTH-1];
            mag_reg   <= dc[COUNT_WIDTH-1] ? (~dc + 1'b1) : dc;
            dt_reg    <= dt;
            zero_reg  <= (target_reg == '0);
            fault_reg <= (target_reg != '0) && (dt == '0);
            speed_reg <= '0;
        end

        if (state_reg == S_SAT)
        begin
            speed_reg <= speed_sat;
        end

        if (state_reg == S_ERR)
        begin
            eneg_reg <= err[RPM_W];
            emag_reg <= EMAG_W'(err_abs);
        end

        if ((state_reg == S_FIN) && res_free)
        begin
            res_drive_reg   <= zero_reg ? '0 : drive_level_reg;
            res_rpm_reg     <= speed_reg;
            res_stalled_reg <= !zero_reg && (speed_reg == '0);
            res_fault_reg   <= fault_reg;
        end
    end

    assign cmd.ready        = (state_reg == S_IDLE);
    assign res.valid        = res_valid_reg;
    assign res.drive        = res_drive_reg;
    assign res.measured_rpm = res_rpm_reg;
    assign res.stalled      = res_stalled_reg;
    assign res.time_fault   = res_fault_reg;
endmodule

[design/msr_checker.sv]
`timescale 1ns / 1ps
`include "motor_speed_regulator_core_macros.svh"
module msr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cmd_valid,
    input logic                               cmd_ready,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic signed [msr_pkg::DRIVE_W-1:0] res_drive,
    input logic signed [msr_pkg::RPM_W-1:0]   res_rpm,
    input logic                               res_stalled,
    input logic                               res_fault
);
    import msr_pkg::*;

    // A result waiting on the receiver stays offered and unchanged.
    `MSR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
    `MSR_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_drive) && $stable(res_rpm))

    // One request at a time: acceptance closes the input for the next cycle.
    `MSR_ASSERT_NEXT(a_one_at_a_time, cmd_valid && cmd_ready, !cmd_ready)

    // The drive clamp is symmetric, so the most negative code never shows.
    `MSR_ASSERT_NOW(a_drive_range, res_valid, res_drive != -DRIVE_W'(RPM_NEG_MAG))

    // A time fault forces a zero speed, which is reported as a stall.
    `MSR_ASSERT_NOW(a_fault_stall, res_valid && res_fault, res_stalled && (res_rpm == '0))
endmodule

bind motor_speed_regulator_core msr_checker u_msr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_drive   (res.drive),
    .res_rpm     (res.measured_rpm),
    .res_stalled (res.stalled),
    .res_fault   (res.time_fault)
);
